// ===== rtl/core/mfbp_pkg.sv =====
`default_nettype none
package mfbp_pkg;

   localparam int BUFFER_BYTES = 65536;
   localparam int COUNT_WIDTH = $clog2(BUFFER_BYTES + 1);
   localparam int CMP_WIDTH = COUNT_WIDTH + 2;

   localparam int FIELD_WIDTH = 24;
   localparam int LENGTH_WIDTH = 5;
   localparam int TOTAL_WIDTH = 20;
   localparam int ACC_WIDTH = 31;
   localparam int BYTES_PER_ITEM = 3;

   localparam int QUEUE_ENTRIES = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_ENTRIES);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_ENTRIES + 1);

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_FLUSH = 2'd1;
   localparam logic [1:0] MODE_RESET = 2'd2;

   localparam logic [LENGTH_WIDTH-1:0] FIELD_MAX_LENGTH = LENGTH_WIDTH'(24);
   localparam logic [LENGTH_WIDTH-1:0] FLUSH_LENGTH = LENGTH_WIDTH'(7);

   typedef struct packed {
      logic [1:0]              mode;
      logic [FIELD_WIDTH-1:0]  field_bits;
      logic [LENGTH_WIDTH-1:0] field_length;
   } req_type;

   typedef struct packed {
      logic [7:0]             byte_value;
      logic                   byte_valid;
      logic                   last;
      logic [TOTAL_WIDTH-1:0] bits_written;
      logic                   overflow;
   } rsp_type;

   typedef struct packed {
      logic [BYTES_PER_ITEM-1:0][7:0] byte_list;
      logic [1:0]                     num_valid;
      logic [TOTAL_WIDTH-1:0]         bits_written;
      logic                           overflow;
   } work_type;

endpackage
`default_nettype wire

// ===== rtl/core/mfbp_queue.sv =====
`default_nettype none
module mfbp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mfbp_pkg::work_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output mfbp_pkg::work_type     pop_data,
   output logic                   empty
);
   import mfbp_pkg::*;

   work_type                     entry_ff [QUEUE_ENTRIES];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                         do_push, do_pop;

   assign full     = (count_ff == QUEUE_COUNT_WIDTH'(QUEUE_ENTRIES));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_ENTRIES - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_ENTRIES - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/mfbp_front.sv =====
`default_nettype none
module mfbp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire mfbp_pkg::req_type  req_payload,
   output logic                   req_full,
   output logic                   work_push,
   output mfbp_pkg::work_type     work_data,
   input  wire logic              work_full
);
   import mfbp_pkg::*;

   logic [6:0]             pending_bits_ff, pending_bits_in;
   logic [2:0]             pending_count_ff, pending_count_in;
   logic [COUNT_WIDTH-1:0] bytes_ff, bytes_in;
   logic                   overflow_ff, overflow_in;

   logic                    accept;
   logic [FIELD_WIDTH-1:0]  bits;
   logic [LENGTH_WIDTH-1:0] len;
   logic [ACC_WIDTH-1:0]    acc;
   logic [4:0]              cnt;
   logic [31:0]             aligned;
   logic [1:0]              num_bytes, emit;
   logic [CMP_WIDTH-1:0]    remaining;
   logic [COUNT_WIDTH-1:0]  bytes_new;
   logic                    overflow_new;
   logic [6:0]              pending_new;
   logic [COUNT_WIDTH+2:0]  total;

   assign req_full  = work_full;
   assign accept    = req_push && !work_full;
   assign work_push = accept;

   always_comb begin
      bits = req_payload.field_bits;
      len  = req_payload.field_length;
      if (req_payload.mode == MODE_FLUSH) begin
         bits = '0;
         len  = FLUSH_LENGTH;
      end
      if (len > FIELD_MAX_LENGTH) begin
         len = FIELD_MAX_LENGTH;
      end
      bits      = bits & ~({FIELD_WIDTH{1'b1}} << len);
      acc       = (ACC_WIDTH'(pending_bits_ff) << len) | ACC_WIDTH'(bits);
      cnt       = 5'(pending_count_ff) + len;
      aligned   = 32'(acc) << (6'd32 - {1'b0, cnt});
      num_bytes = cnt[4:3];
      remaining = CMP_WIDTH'(BUFFER_BYTES) - CMP_WIDTH'(bytes_ff);
      if (overflow_ff) begin
         emit = 2'd0;
      end else if (remaining < CMP_WIDTH'(num_bytes)) begin
         emit = 2'(remaining);
      end else begin
         emit = num_bytes;
      end
      bytes_new    = bytes_ff + COUNT_WIDTH'(emit);
      overflow_new = overflow_ff || (bytes_new == COUNT_WIDTH'(BUFFER_BYTES));
      pending_new  = acc[6:0] & ~(7'h7f << cnt[2:0]);

      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      bytes_in         = bytes_ff;
      overflow_in      = overflow_ff;
      work_data.num_valid = 2'd0;
      unique case (req_payload.mode)
         MODE_WRITE, MODE_FLUSH: begin
            pending_bits_in     = pending_new;
            pending_count_in    = cnt[2:0];
            bytes_in            = bytes_new;
            overflow_in         = overflow_new;
            work_data.num_valid = emit;
         end
         MODE_RESET: begin
            pending_bits_in  = '0;
            pending_count_in = '0;
            bytes_in         = '0;
            overflow_in      = 1'b0;
         end
         default: begin
         end
      endcase

      total = {bytes_in, pending_count_in};
      work_data.byte_list[0]  = aligned[31:24];
      work_data.byte_list[1]  = aligned[23:16];
      work_data.byte_list[2]  = aligned[15:8];
      work_data.bits_written  = TOTAL_WIDTH'(total);
      work_data.overflow      = overflow_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         bytes_ff         <= '0;
         overflow_ff      <= 1'b0;
      end else if (accept) begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         bytes_ff         <= bytes_in;
         overflow_ff      <= overflow_in;
      end
   end

   overflow_needs_full_count: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> bytes_ff == COUNT_WIDTH'(BUFFER_BYTES))
      else $error("overflow set below the byte limit");

   count_within_limit: assert property (@(posedge clock) disable iff (reset)
      CMP_WIDTH'(bytes_ff) <= CMP_WIDTH'(BUFFER_BYTES))
      else $error("byte count beyond the limit");

   overflow_clears_on_reset_item: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(overflow_ff)) |-> $past(accept && req_payload.mode == MODE_RESET))
      else $error("overflow cleared without a reset item");

endmodule
`default_nettype wire

// ===== rtl/core/mfbp_back.sv =====
`default_nettype none
module mfbp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mfbp_pkg::work_type work_head,
   input  wire logic              work_empty,
   output logic                   work_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output mfbp_pkg::rsp_type      rsp_payload
);
   import mfbp_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       transfer;

   assign last      = (work_head.num_valid == 2'd0) || (idx_ff == work_head.num_valid - 2'd1);
   assign rsp_empty = work_empty;
   assign transfer  = rsp_pop && !work_empty;
   assign work_pop  = transfer && last;

   always_comb begin
      idx_in = idx_ff;
      if (transfer) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end
      rsp_payload.byte_valid   = (work_head.num_valid != 2'd0);
      rsp_payload.byte_value   = rsp_payload.byte_valid ? work_head.byte_list[idx_ff] : 8'd0;
      rsp_payload.last         = last;
      rsp_payload.bits_written = work_head.bits_written;
      rsp_payload.overflow     = work_head.overflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   status_is_single: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_payload.byte_valid) |-> rsp_payload.last)
      else $error("status result not marked last");

   index_needs_entry: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> !work_empty)
      else $error("result index advanced with no pending entry");

   index_within_entry: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> idx_ff < work_head.num_valid)
      else $error("result index beyond the entry's bytes");

endmodule
`default_nettype wire

// ===== rtl/core/msb_first_bit_packer.sv =====
`default_nettype none
// msb-first bit packer: write items append up to 24 bits msb first to the pending bits,
// flush items append seven zero bits, reset items clear pending bits, byte count and
// overflow. each item gives one result per completed byte (up to three) or one status
// result with byte_valid low; last marks its final result and every result carries
// bits_written and overflow as they stand after the item. the front takes one item per
// cycle while the queue is not full and classifies it in that cycle; the back delivers
// one result per pop transfer, so an item takes as many transfers as it has results.
// a two-entry queue between front and back lets the front keep taking items while
// results wait. once BUFFER_BYTES bytes have gone out, overflow stays set and later
// bytes are dropped until a reset item.
module msb_first_bit_packer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire mfbp_pkg::req_type  req_payload,
   output logic                   req_full,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output mfbp_pkg::rsp_type      rsp_payload
);
   import mfbp_pkg::*;

   logic     work_push, work_full, work_pop, work_empty;
   work_type work_data, work_head;

   mfbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .work_push   (work_push),
      .work_data   (work_data),
      .work_full   (work_full)
   );

   mfbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (work_push),
      .push_data (work_data),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_head),
      .empty     (work_empty)
   );

   mfbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .work_head   (work_head),
      .work_empty  (work_empty),
      .work_pop    (work_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ===== verif/mfbp_stream_check.sv =====
`timescale 1ns / 1ps
module mfbp_stream_check (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   input  wire mfbp_pkg::req_type req_payload,
   input  wire logic              req_full,
   input  wire logic              rsp_empty,
   input  wire logic              rsp_pop,
   input  wire mfbp_pkg::rsp_type rsp_payload,
   output int                     errors,
   output int                     in_flight
);
   import mfbp_pkg::*;

   logic [6:0]  held_bits;
   logic [2:0]  held_count;
   logic [16:0] byte_count;
   logic        full_flag;
   rsp_type     byte_q[$];
   rsp_type     want;

   initial begin
      errors = 0;
      in_flight = 0;
   end

   task automatic predict_bytes(input req_type item);
      logic [30:0] acc;
      logic [31:0] mask;
      logic [23:0] bits;
      logic [4:0]  len;
      logic [7:0]  out_bytes [3];
      logic [7:0]  b;
      rsp_type     r;
      int          cnt;
      int          n;
      n = 0;
      if (item.mode == MODE_RESET) begin
         held_bits = '0;
         held_count = '0;
         byte_count = '0;
         full_flag = 1'b0;
      end else if (item.mode == MODE_WRITE || item.mode == MODE_FLUSH) begin
         bits = item.field_bits;
         len = item.field_length;
         if (item.mode == MODE_FLUSH) begin
            bits = '0;
            len = FLUSH_LENGTH;
         end
         if (len > FIELD_MAX_LENGTH) len = FIELD_MAX_LENGTH;
         mask = (32'd1 << len) - 32'd1;
         bits = bits & mask[23:0];
         acc = (31'(held_bits) << len) | 31'(bits);
         cnt = int'(held_count) + int'(len);
         while (cnt >= 8) begin
            b = 8'(acc >> (cnt - 8));
            cnt -= 8;
            acc = acc & ((31'd1 << cnt) - 31'd1);
            if (!full_flag && n < 3) begin
               out_bytes[n] = b;
               n++;
               byte_count = byte_count + 17'd1;
               if (int'(byte_count) >= BUFFER_BYTES) full_flag = 1'b1;
            end
         end
         held_bits = acc[6:0];
         held_count = 3'(cnt);
      end
      r.bits_written = TOTAL_WIDTH'(int'(byte_count) * 8 + int'(held_count));
      r.overflow = full_flag;
      if (n == 0) begin
         r.byte_value = '0;
         r.byte_valid = 1'b0;
         r.last = 1'b1;
         byte_q.push_back(r);
      end else begin
         for (int k = 0; k < n; k++) begin
            r.byte_value = out_bytes[k];
            r.byte_valid = 1'b1;
            r.last = (k == n - 1);
            byte_q.push_back(r);
         end
      end
   endtask

   task automatic check_field(input string field_name, input logic [31:0] want_val,
                              input logic [31:0] got_val);
      if (want_val !== got_val) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, field_name,
                  want_val, got_val);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_bits = '0;
         held_count = '0;
         byte_count = '0;
         full_flag = 1'b0;
         byte_q.delete();
         in_flight <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (byte_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none actual %p", $time,
                        rsp_payload);
            end else begin
               want = byte_q.pop_front();
               check_field("byte_value", 32'(want.byte_value), 32'(rsp_payload.byte_value));
               check_field("byte_valid", 32'(want.byte_valid), 32'(rsp_payload.byte_valid));
               check_field("last", 32'(want.last), 32'(rsp_payload.last));
               check_field("bits_written", 32'(want.bits_written),
                           32'(rsp_payload.bits_written));
               check_field("overflow", 32'(want.overflow), 32'(rsp_payload.overflow));
            end
         end
         if (req_push && !req_full) predict_bytes(req_payload);
         in_flight <= byte_q.size();
      end
   end

endmodule

// ===== verif/tb_msb_first_bit_packer.sv =====
`timescale 1ns / 1ps
module tb_msb_first_bit_packer;
   import mfbp_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 500000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_payload = '0;
   logic    rsp_pop = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_payload;
   int      errors;
   int      in_flight;
   int      cycles = 0;
   bit      gaps_on = 1'b1;

   always #5 clock = ~clock;

   msb_first_bit_packer dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

   mfbp_stream_check stream_check (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .errors      (errors),
      .in_flight   (in_flight)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_msb_first_bit_packer: done, errors");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [23:0] bits,
                            input logic [4:0] len);
      req_type item;
      int      gap;
      item.mode = mode;
      item.field_bits = bits;
      item.field_length = len;
      req_payload <= item;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      int          pick;
      logic [1:0]  mode;
      logic [4:0]  len;
      pick = $urandom_range(0, 99);
      if (pick < 75) mode = MODE_WRITE;
      else if (pick < 88) mode = MODE_FLUSH;
      else if (pick < 94) mode = MODE_RESET;
      else mode = MODE_SPARE;
      len = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(25, 31))
                                          : 5'($urandom_range(0, 24));
      send_item(mode, 24'($urandom()), len);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   // result side: random stall before each transfer while gaps are on
   initial begin
      int gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = gaps_on ? $urandom_range(0, 9) : 0;
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_WRITE, 24'hFFFFFF, 5'd0);
      send_item(MODE_WRITE, 24'hFFFFFF, 5'd24);
      send_item(MODE_WRITE, 24'h000000, 5'd24);
      send_item(MODE_WRITE, 24'hFFFFF5, 5'd3);
      send_item(MODE_FLUSH, 24'hFFFFFF, 5'd31);
      send_item(MODE_FLUSH, 24'h000000, 5'd0);
      send_item(MODE_WRITE, 24'h000001, 5'd1);
      send_item(MODE_WRITE, 24'hA5A5A5, 5'd31);
      send_item(MODE_WRITE, 24'h5A5A5A, 5'd25);
      send_item(MODE_WRITE, 24'h00007F, 5'd7);
      send_item(MODE_WRITE, 24'hFFFFFF, 5'd24);
      send_item(MODE_SPARE, 24'hABCDEF, 5'd17);
      send_item(MODE_WRITE, 24'h123456, 5'd23);
      send_item(MODE_RESET, 24'hFFFFFF, 5'd31);
      send_item(MODE_WRITE, 24'h800001, 5'd24);
      send_item(MODE_WRITE, 24'h000001, 5'd8);
      send_item(MODE_WRITE, 24'hFFFF00, 5'd16);
      send_item(MODE_WRITE, 24'h000003, 5'd2);
      send_item(MODE_FLUSH, 24'h000000, 5'd7);
      send_item(MODE_RESET, 24'h000000, 5'd0);
      wait_drained();

      for (int i = 0; i < 200; i++) begin
         gaps_on = ((i / 40) % 3) != 2;
         send_random();
      end
      gaps_on = 1'b1;
      wait_drained();

      // fresh start, writes of random length, then flush, spare and reset items, then random items
      send_item(MODE_RESET, 24'h000000, 5'd0);
      for (int i = 0; i < 8; i++) send_item(MODE_WRITE, 24'($urandom()), 5'($urandom_range(0, 31)));
      send_item(MODE_FLUSH, 24'h000000, 5'd0);
      send_item(MODE_SPARE, 24'($urandom()), 5'd24);
      send_item(MODE_RESET, 24'($urandom()), 5'd24);
      for (int i = 0; i < 20; i++) send_random();

      req_push <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb_msb_first_bit_packer: done, clean");
      end else begin
         $display("tb_msb_first_bit_packer: done, errors");
      end
      $finish;
   end

endmodule
